### rtl/ael_pkg.sv
// shared types and constants for the arithmetic expression lexer
// scanner states, token kinds, character codes and channel payload structs
// no dependencies
package ael_pkg;

    localparam int MAX_TOKEN_LENGTH_DEFAULT = 255;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_IDENT = 3'd1,
        ST_INT   = 3'd2,
        ST_DOT   = 3'd3,
        ST_REAL  = 3'd4,
        ST_EQ    = 3'd5
    } scan_state_t;

    typedef enum logic [3:0] {
        TK_ERROR  = 4'd0,
        TK_IDENT  = 4'd1,
        TK_INT    = 4'd2,
        TK_REAL   = 4'd3,
        TK_PLUS   = 4'd4,
        TK_MINUS  = 4'd5,
        TK_STAR   = 4'd6,
        TK_SLASH  = 4'd7,
        TK_LPAR   = 4'd8,
        TK_RPAR   = 4'd9,
        TK_POW    = 4'd10,
        TK_ASSIGN = 4'd11,
        TK_EQEQ   = 4'd12
    } token_kind_t;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_POW   = 8'h5E;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    typedef struct packed {
        logic [7:0] char_in;
        logic       is_end;
    } ael_in_t;

    typedef struct packed {
        logic [3:0] token_kind;
        logic [7:0] token_length;
        logic       last;
    } ael_out_t;

    typedef struct packed {
        token_kind_t kind;
        logic [7:0]  length;
    } ael_token_t;

    // one queue entry holds every token caused by one character
    typedef struct packed {
        logic       two;
        ael_token_t tok_a;
        ael_token_t tok_b;
    } ael_entry_t;

endpackage

### rtl/arithmetic_expression_lexer.sv
// top level of the arithmetic expression lexer: front end, token queue, output side
// depends on ael_pkg, ael_front, ael_queue, ael_back
//
//   port group   direction   payload     transaction when
//   s_*          in          ael_in_t    s_valid && s_ready
//   m_*          out         ael_out_t   m_valid && m_ready
//
// one character is taken per cycle while the queue is not full
// a character that ends one token and starts an operator yields two tokens, which
// leave one per output transaction; a four-entry queue absorbs this and s_ready
// drops only when the queue is full
// synchronous reset returns the scanner to idle and empties the queue and output
module arithmetic_expression_lexer
    import ael_pkg::*;
#(
    parameter int MAX_TOKEN_LENGTH = MAX_TOKEN_LENGTH_DEFAULT
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  ael_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output ael_out_t m_data
);

    logic       push, pop, q_full, q_empty;
    ael_entry_t push_data, head;

    ael_front #(
        .MAX_TOKEN_LENGTH(MAX_TOKEN_LENGTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .q_full   (q_full),
        .push     (push),
        .push_data(push_data)
    );

    ael_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_data(push_data),
        .full     (q_full),
        .pop      (pop),
        .empty    (q_empty),
        .head     (head)
    );

    ael_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .empty   (q_empty),
        .head    (head),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

### rtl/ael_front.sv
// front end: accepts characters, classifies them and steps the scanner
// pushes the tokens of each character as one entry into the queue
// depends on ael_pkg
module ael_front
    import ael_pkg::*;
#(
    parameter int MAX_TOKEN_LENGTH = MAX_TOKEN_LENGTH_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  ael_in_t    s_data,
    input  logic       q_full,
    output logic       push,
    output ael_entry_t push_data
);

    localparam int CAP_INT = (MAX_TOKEN_LENGTH < 255) ? MAX_TOKEN_LENGTH : 255;
    localparam logic [7:0] LEN_CAP = CAP_INT[7:0];

    scan_state_t state_reg, state_next;
    logic [7:0]  count_reg, count_next;

    logic        accept;
    logic [7:0]  c;
    logic        is_end;
    logic        is_letter, is_digit, is_op;
    token_kind_t op_kind;
    logic [7:0]  count_inc;
    logic        pend, repro;
    token_kind_t pend_kind;
    logic [7:0]  pend_len;
    logic        op_emit;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign c       = s_data.char_in;
    assign is_end  = s_data.is_end;

    assign is_letter = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A)
                       || c == CH_UNDER;
    assign is_digit  = c >= 8'h30 && c <= 8'h39;
    assign count_inc = (count_reg < LEN_CAP) ? count_reg + 8'd1 : count_reg;

    always_comb begin
        is_op   = 1'b1;
        op_kind = TK_ERROR;
        case (c)
            CH_PLUS:  op_kind = TK_PLUS;
            CH_MINUS: op_kind = TK_MINUS;
            CH_STAR:  op_kind = TK_STAR;
            CH_SLASH: op_kind = TK_SLASH;
            CH_LPAR:  op_kind = TK_LPAR;
            CH_RPAR:  op_kind = TK_RPAR;
            CH_POW:   op_kind = TK_POW;
            default:  is_op = 1'b0;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        pend       = 1'b0;
        pend_kind  = TK_ERROR;
        pend_len   = count_reg;
        repro      = 1'b0;
        case (state_reg)
            ST_IDENT: begin
                if (!is_end && (is_letter || is_digit)) begin
                    count_next = count_inc;
                end else begin
                    pend      = 1'b1;
                    pend_kind = TK_IDENT;
                    repro     = !is_end;
                end
            end
            ST_INT: begin
                if (!is_end && is_digit) begin
                    count_next = count_inc;
                end else if (!is_end && c == CH_DOT) begin
                    count_next = count_inc;
                    state_next = ST_DOT;
                end else begin
                    pend      = 1'b1;
                    pend_kind = TK_INT;
                    repro     = !is_end;
                end
            end
            ST_DOT: begin
                if (!is_end && is_digit) begin
                    count_next = count_inc;
                    state_next = ST_REAL;
                end else begin
                    pend      = 1'b1;
                    pend_kind = TK_ERROR;
                    repro     = !is_end;
                end
            end
            ST_REAL: begin
                if (!is_end && is_digit) begin
                    count_next = count_inc;
                end else begin
                    pend      = 1'b1;
                    pend_kind = TK_REAL;
                    repro     = !is_end;
                end
            end
            ST_EQ: begin
                pend = 1'b1;
                if (!is_end && c == CH_EQ) begin
                    pend_kind = TK_EQEQ;
                    pend_len  = 8'd2;
                end else begin
                    pend_kind = TK_ASSIGN;
                    repro     = !is_end;
                end
            end
            default: begin
                repro = !is_end;
            end
        endcase

        if (pend || is_end) begin
            state_next = ST_IDLE;
            count_next = 8'd0;
        end

        // character handled again from idle
        op_emit = 1'b0;
        if (repro) begin
            state_next = ST_IDLE;
            count_next = 8'd0;
            if (is_letter) begin
                state_next = ST_IDENT;
                count_next = 8'd1;
            end else if (is_digit) begin
                state_next = ST_INT;
                count_next = 8'd1;
            end else if (c == CH_EQ) begin
                state_next = ST_EQ;
                count_next = 8'd1;
            end else begin
                op_emit = is_op;
            end
        end
    end

    always_comb begin
        push_data.two          = pend && op_emit;
        push_data.tok_a.kind   = pend ? pend_kind : op_kind;
        push_data.tok_a.length = pend ? pend_len : 8'd1;
        push_data.tok_b.kind   = op_kind;
        push_data.tok_b.length = 8'd1;
        push                   = accept && (pend || op_emit);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= 8'd0;
        end else if (accept) begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

endmodule

### rtl/ael_queue.sv
// short queue of token entries between the front end and the output side
// lets either side stall without holding up the other
// depends on ael_pkg
module ael_queue
    import ael_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  ael_entry_t push_data,
    output logic       full,
    input  logic       pop,
    output logic       empty,
    output ael_entry_t head
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

    ael_entry_t           slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]     fill_reg;
    logic                 do_push, do_pop;

    assign full    = fill_reg == DEPTH_C;
    assign empty   = fill_reg == '0;
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                fill_reg <= fill_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                fill_reg <= fill_reg - CNT_W'(1);
            end
        end
    end

endmodule

### rtl/ael_back.sv
// output side: takes entries from the queue and hands out one token per transaction
// marks last on the final token of each entry
// depends on ael_pkg
module ael_back
    import ael_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       empty,
    input  ael_entry_t head,
    output logic       pop,
    output logic       m_valid,
    input  logic       m_ready,
    output ael_out_t   m_data
);

    logic       hold_valid_reg;
    ael_entry_t hold_reg;
    logic       phase_reg;

    logic       finish, advance, load;
    ael_token_t cur;

    assign finish  = hold_valid_reg && m_ready && (!hold_reg.two || phase_reg);
    assign advance = hold_valid_reg && m_ready && hold_reg.two && !phase_reg;
    assign load    = (!hold_valid_reg || finish) && !empty;
    assign pop     = load;

    assign cur                 = phase_reg ? hold_reg.tok_b : hold_reg.tok_a;
    assign m_valid             = hold_valid_reg;
    assign m_data.token_kind   = cur.kind;
    assign m_data.token_length = cur.length;
    assign m_data.last         = !hold_reg.two || phase_reg;

    always_ff @(posedge aclk) begin
        if (load) begin
            hold_reg <= head;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            phase_reg      <= 1'b0;
        end else begin
            if (load) begin
                hold_valid_reg <= 1'b1;
                phase_reg      <= 1'b0;
            end else if (finish) begin
                hold_valid_reg <= 1'b0;
                phase_reg      <= 1'b0;
            end else if (advance) begin
                phase_reg <= 1'b1;
            end
        end
    end

endmodule

### verif/arithmetic_expression_lexer_test.sv
`timescale 1ns / 100ps
// self-checking testbench for arithmetic_expression_lexer: character stream in, tokens out
// depends on ael_pkg and the lexer rtl; predicts every token and checks it field by field
module arithmetic_expression_lexer_test;
    import ael_pkg::*;

    localparam int LEN_CAP = (MAX_TOKEN_LENGTH_DEFAULT < 255) ? MAX_TOKEN_LENGTH_DEFAULT : 255;
    localparam int RANDOM_CHARS = 1750;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 20;

    logic     aclk;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    ael_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    ael_out_t m_data;

    ael_in_t     source_chars[$];
    ael_out_t    expected_tokens[$];
    scan_state_t scan_st = ST_IDLE;
    logic [7:0]  tok_len = '0;

    int total_chars = 0;
    int chars_taken = 0;
    int errors = 0;
    int cycle_count = 0;
    int gap_left = 0;
    int burst_left = 0;
    logic [15:0] rx_pattern = 16'hFFFF;
    logic [7:0]  rx_phase = '0;

    arithmetic_expression_lexer i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------- token predictor

    function automatic bit is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
    endfunction

    function automatic bit is_num(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic void count_char();
        if (tok_len < LEN_CAP) tok_len++;
    endfunction

    function automatic void predict_tokens(input ael_in_t item);
        logic [7:0]  c;
        logic        fin;
        bit          flush;
        bit          redo;
        token_kind_t flush_kind;
        ael_out_t    toks[$];
        c = item.char_in;
        fin = item.is_end;
        flush = 0;
        redo = 0;
        flush_kind = TK_ERROR;
        case (scan_st)
            ST_IDENT: begin
                if (!fin && (is_alpha(c) || is_num(c))) count_char();
                else begin flush = 1; flush_kind = TK_IDENT; end
            end
            ST_INT: begin
                if (!fin && is_num(c)) count_char();
                else if (!fin && c == CH_DOT) begin
                    count_char();
                    scan_st = ST_DOT;
                end else begin
                    flush = 1; flush_kind = TK_INT;
                end
            end
            ST_DOT: begin
                if (!fin && is_num(c)) begin
                    count_char();
                    scan_st = ST_REAL;
                end else begin
                    flush = 1; flush_kind = TK_ERROR;
                end
            end
            ST_REAL: begin
                if (!fin && is_num(c)) count_char();
                else begin flush = 1; flush_kind = TK_REAL; end
            end
            ST_EQ: begin
                if (!fin && c == CH_EQ) begin
                    toks.push_back('{token_kind: TK_EQEQ, token_length: 8'd2, last: 1'b0});
                    scan_st = ST_IDLE;
                    tok_len = '0;
                end else begin
                    flush = 1; flush_kind = TK_ASSIGN;
                end
            end
            default: begin
                if (fin) begin
                    scan_st = ST_IDLE;
                    tok_len = '0;
                end else begin
                    redo = 1;
                end
            end
        endcase
        if (flush) begin
            toks.push_back('{token_kind: flush_kind, token_length: tok_len, last: 1'b0});
            scan_st = ST_IDLE;
            tok_len = '0;
            redo = !fin;
        end
        // the terminating character starts afresh from idle
        if (redo) begin
            scan_st = ST_IDLE;
            tok_len = '0;
            if (is_alpha(c)) begin
                scan_st = ST_IDENT; tok_len = 8'd1;
            end else if (is_num(c)) begin
                scan_st = ST_INT; tok_len = 8'd1;
            end else if (c == CH_EQ) begin
                scan_st = ST_EQ; tok_len = 8'd1;
            end else begin
                case (c)
                    CH_PLUS:  toks.push_back('{TK_PLUS, 8'd1, 1'b0});
                    CH_MINUS: toks.push_back('{TK_MINUS, 8'd1, 1'b0});
                    CH_STAR:  toks.push_back('{TK_STAR, 8'd1, 1'b0});
                    CH_SLASH: toks.push_back('{TK_SLASH, 8'd1, 1'b0});
                    CH_LPAR:  toks.push_back('{TK_LPAR, 8'd1, 1'b0});
                    CH_RPAR:  toks.push_back('{TK_RPAR, 8'd1, 1'b0});
                    CH_POW:   toks.push_back('{TK_POW, 8'd1, 1'b0});
                    default: ;
                endcase
            end
        end
        if (toks.size() != 0) toks[toks.size() - 1].last = 1'b1;
        foreach (toks[i]) expected_tokens.push_back(toks[i]);
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic void add_char(input logic [7:0] c);
        source_chars.push_back('{char_in: c, is_end: 1'b0});
    endfunction

    function automatic void add_end(input logic [7:0] junk);
        source_chars.push_back('{char_in: junk, is_end: 1'b1});
    endfunction

    function automatic void add_text(input string text);
        for (int i = 0; i < text.len(); i++) add_char(text[i]);
    endfunction

    function automatic logic [7:0] pick_letter();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26) return 8'("a" + r);
        if (r < 52) return 8'("A" + r - 26);
        return CH_UNDER;
    endfunction

    function automatic logic [7:0] pick_digit();
        return 8'("0" + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] pick_alnum();
        return ($urandom_range(0, 3) == 0) ? pick_digit() : pick_letter();
    endfunction

    function automatic void add_digits(input int lo, input int hi);
        int n;
        n = $urandom_range(lo, hi);
        repeat (n) add_char(pick_digit());
    endfunction

    function automatic void add_random_token();
        int choice;
        int n;
        logic [7:0] ops[7];
        ops = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_LPAR, CH_RPAR, CH_POW};
        choice = $urandom_range(0, 399);
        if (choice < 80) begin
            add_char(pick_letter());
            n = $urandom_range(0, 8);
            repeat (n) add_char(pick_alnum());
        end else if (choice < 140) begin
            add_digits(1, 6);
        end else if (choice < 180) begin
            add_digits(1, 4);
            add_char(CH_DOT);
            add_digits(1, 4);
        end else if (choice < 200) begin
            // dot with nothing after it, or a non-digit straight after
            add_digits(1, 3);
            add_char(CH_DOT);
            if ($urandom_range(0, 1) == 0) add_char(ops[$urandom_range(0, 6)]);
        end else if (choice < 300) begin
            add_char(ops[$urandom_range(0, 6)]);
        end else if (choice < 340) begin
            add_char(CH_EQ);
            if ($urandom_range(0, 1) == 0) add_char(CH_EQ);
        end else if (choice < 372) begin
            add_end(8'($urandom));
        end else if (choice < 398) begin
            n = $urandom_range(1, 3);
            repeat (n) add_char(8'($urandom));
        end else begin
            // rare long token to reach length saturation
            n = $urandom_range(256, 300);
            if (choice == 398) begin
                add_char(pick_letter());
                repeat (n - 1) add_char(pick_alnum());
            end else begin
                repeat (n) add_char(pick_digit());
            end
        end
        case ($urandom_range(0, 4))
            0, 1: ;
            2, 3: add_char(" ");
            default: add_char(8'($urandom));
        endcase
    endfunction

    task automatic report_error(input string msg);
        $display("ERROR cycle %0d: %s", cycle_count, msg);
        errors++;
    endtask

    // ---------------------------------------------------------------- driver

    always @(posedge aclk) begin : drive_chars
        ael_in_t next_item;
        logic    next_valid;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            next_valid = 1'b0;
            next_item = s_data;
            if (gap_left != 0) begin
                gap_left--;
            end else if (source_chars.size() != 0) begin
                next_item = source_chars.pop_front();
                next_valid = 1'b1;
                if (burst_left > 0) burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            s_valid <= next_valid;
            s_data <= next_item;
        end
    end

    // receiver stalls follow a 16-bit ready pattern, redrawn when the 8-bit phase wraps
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (rx_phase == 0)
                rx_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
            m_ready <= rx_pattern[rx_phase[3:0]];
            rx_phase++;
        end
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge aclk) begin : watch_channels
        ael_out_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_tokens(s_data);
                chars_taken++;
            end
            if (m_valid && m_ready) begin
                if (expected_tokens.size() == 0) begin
                    report_error($sformatf("unexpected token kind %0d length %0d last %0b",
                        m_data.token_kind, m_data.token_length, m_data.last));
                end else begin
                    want = expected_tokens.pop_front();
                    if (m_data.token_kind !== want.token_kind)
                        report_error($sformatf("token_kind %0d, expected %0d",
                            m_data.token_kind, want.token_kind));
                    if (m_data.token_length !== want.token_length)
                        report_error($sformatf("token_length %0d, expected %0d",
                            m_data.token_length, want.token_length));
                    if (m_data.last !== want.last)
                        report_error($sformatf("last %0b, expected %0b",
                            m_data.last, want.last));
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        // directed: every operator, all token kinds, both equals forms, end flushes
        add_text("_aZ9+12.5*(x-3.)/7^y==z=");
        add_char(8'h80);
        add_char(8'hFF);
        add_char(8'h00);
        add_text("4");
        add_end(8'hFF);
        add_text("=");
        add_end(8'h00);
        add_text("7.");
        add_end(8'h5A);
        add_end(8'hA5);
        // saturating identifier, then a saturating integer ended by an operator
        add_char("q");
        repeat (299) add_char(pick_alnum());
        add_end(8'h00);
        repeat (260) add_char(pick_digit());
        add_char(CH_PLUS);
        while (source_chars.size() < RANDOM_CHARS) add_random_token();
        add_end(8'h00);
        total_chars = source_chars.size();

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        do @(negedge aclk);
        while (chars_taken != total_chars || expected_tokens.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (errors == 0 && expected_tokens.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
